// ===== hw/rtl/hre_pkg.sv =====
// Shared types and constants of the PPG heart-rate estimator.
// Configuration record, status codes, register indexes, filter coefficients.
// No dependencies.
package hre_pkg;

  // Configuration register bank as seen by the datapath
  typedef struct packed {
    logic [15:0] report_period_ms;
    logic [15:0] warmup_ms;
    logic [10:0] min_interval_ms;
    logic [10:0] max_interval_ms;
    logic [17:0] min_peak_threshold;
    logic [17:0] min_signal_amplitude;
    logic [3:0]  min_intervals_for_report;
  } cfg_t;

  // Register indexes on the configuration port
  typedef enum logic [2:0] {
    REG_REPORT_PERIOD = 3'd0,
    REG_WARMUP        = 3'd1,
    REG_MIN_INTERVAL  = 3'd2,
    REG_MAX_INTERVAL  = 3'd3,
    REG_MIN_PEAK_THR  = 3'd4,
    REG_MIN_AMPLITUDE = 3'd5,
    REG_MIN_INTERVALS = 3'd6
  } cfg_idx_t;

  // Report status codes
  typedef enum logic [2:0] {
    STS_NO_FINGER    = 3'd0,
    STS_WARMING_UP   = 3'd1,
    STS_POOR_SIGNAL  = 3'd2,
    STS_INSUFFICIENT = 3'd3,
    STS_STABLE       = 3'd4
  } status_t;

  // Q16 filter coefficients: 0.01, 0.20, 0.995
  localparam logic [16:0] K_BASE   = 17'd655;
  localparam logic [16:0] K_SMOOTH = 17'd13107;
  localparam logic [16:0] K_DECAY  = 17'd65208;

  // Square saturation value, 2^62
  localparam logic [63:0] SQ_CAP = 64'h4000_0000_0000_0000;

  // Rate window on twice the median interval: 40..180 BPM
  localparam int RATE_MS_X2 = 120000;
  localparam int MIN_BPM    = 40;
  localparam int MAX_BPM    = 180;
  localparam logic [11:0] MAX_M2 = 12'(RATE_MS_X2 / MIN_BPM);
  localparam logic [11:0] MIN_M2 = 12'((RATE_MS_X2 + MAX_BPM - 1) / MAX_BPM);

  // 60000 ms * 256 * 2, numerator of the Q8.8 rate from twice the median
  localparam logic [31:0] BPM_NUM = 32'd30720000;

  // Reset values of the configuration registers
  localparam cfg_t CFG_RESET = '{
    report_period_ms:         16'd1000,
    warmup_ms:                16'd8000,
    min_interval_ms:          11'd333,
    max_interval_ms:          11'd1500,
    min_peak_threshold:       18'd50,
    min_signal_amplitude:     18'd500,
    min_intervals_for_report: 4'd3
  };

endpackage

// ===== hw/rtl/hre_front.sv =====
// Front end: accepts sample beats and holds them in a two-entry queue.
// Depends on hre_pkg.
module hre_front
  import hre_pkg::*;
#(
  parameter int SAMPLE_BITS = 18
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [31:0]            in_sample_time_ms,
  input  logic [SAMPLE_BITS-1:0] in_ir_level,
  input  logic                   in_finger_on,
  output logic                   q_valid,
  input  logic                   q_pop,
  output logic [31:0]            q_time,
  output logic [SAMPLE_BITS-1:0] q_ir,
  output logic                   q_finger
);

  logic [31:0]            time_r   [2];
  logic [SAMPLE_BITS-1:0] ir_r     [2];
  logic                   finger_r [2];
  logic                   wr_ptr_r;
  logic                   rd_ptr_r;
  logic [1:0]             count_r;
  logic                   push;
  logic                   pop;

  assign in_ready = (count_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;
  assign q_valid  = (count_r != 2'd0);
  assign q_time   = time_r[rd_ptr_r];
  assign q_ir     = ir_r[rd_ptr_r];
  assign q_finger = finger_r[rd_ptr_r];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      time_r[wr_ptr_r]   <= in_sample_time_ms;
      ir_r[wr_ptr_r]     <= in_ir_level;
      finger_r[wr_ptr_r] <= in_finger_on;
    end
  end

  // pointers and fill
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      if (push && !pop)      count_r <= count_r + 2'd1;
      else if (pop && !push) count_r <= count_r - 2'd1;
    end
  end

endmodule

// ===== hw/rtl/hre_div.sv =====
// Iterative unsigned divider, two quotient bits per cycle.
// Gives the remainder and the low 16 quotient bits. Depends on hre_pkg.
module hre_div
  import hre_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [15:0] quot,
  output logic [15:0] rem
);

  logic [31:0] a_r;
  logic [15:0] d_r;
  logic [15:0] rem_r;
  logic [15:0] q_r;
  logic [3:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [16:0] r1, r2;
  logic        ge1, ge2;
  logic [15:0] rem1, rem2;

  // two restoring steps per cycle
  always_comb begin
    r1   = {rem_r, a_r[31]};
    ge1  = (r1 >= {1'b0, d_r});
    rem1 = ge1 ? 16'(r1 - {1'b0, d_r}) : r1[15:0];
    r2   = {rem1, a_r[30]};
    ge2  = (r2 >= {1'b0, d_r});
    rem2 = ge2 ? 16'(r2 - {1'b0, d_r}) : r2[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        a_r    <= dividend;
        d_r    <= divisor;
        rem_r  <= '0;
        q_r    <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        a_r   <= {a_r[29:0], 2'b00};
        rem_r <= rem2;
        q_r   <= {q_r[13:0], ge1, ge2};
        cnt_r <= cnt_r + 4'd1;
        if (cnt_r == 4'd15) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;
  assign rem  = rem_r;

endmodule

// ===== hw/rtl/hre_back.sv =====
// Back end: per-sample filter sequencer, peak and interval tracking,
// report timing, median selection and rate. Depends on hre_pkg, hre_div.
module hre_back
  import hre_pkg::*;
#(
  parameter int SAMPLE_BITS    = 18,
  parameter int INTERVAL_DEPTH = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cfg_t                   cfg,
  input  logic                   q_valid,
  output logic                   q_pop,
  input  logic [31:0]            q_time,
  input  logic [SAMPLE_BITS-1:0] q_ir,
  input  logic                   q_finger,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [31:0]            out_report_time_ms,
  output logic [2:0]             out_status,
  output logic [3:0]             out_beats,
  output logic [15:0]            out_bpm_q8
);

  localparam int LW  = SAMPLE_BITS + 18;      // signed level width
  localparam int PLW = LW + 17;               // level times coefficient
  localparam int IW  = (INTERVAL_DEPTH > 1) ? $clog2(INTERVAL_DEPTH) : 1;
  localparam int FW  = $clog2(INTERVAL_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_BASE, S_SMOOTH, S_SQ_HH, S_SQ_HL, S_SQ_LL, S_VAR, S_PEAK,
    S_RCHK, S_RDIV, S_STATUS, S_MED, S_M2, S_BDIV, S_EMIT
  } state_t;

  state_t state_r;

  // item being worked on
  logic [31:0]            t_r;
  logic [SAMPLE_BITS-1:0] ir_r;

  // report clock
  logic        clock_started_r;
  logic [32:0] next_r;

  // signal state
  logic                 filter_started_r;
  logic                 contact_r;
  logic [31:0]          cst_r;
  logic [31:0]          pst_r;
  logic [31:0]          lpt_r;
  logic signed [LW-1:0] base_r, sm_r, sp_r, sp2_r, env_r, envd_r;
  logic signed [63:0]   var_r;
  logic [63:0]          sq_sm_r, sq_sp_r, acc_r;
  logic                 sq_sel_r;

  // interval ring
  logic [10:0]   ring_r [INTERVAL_DEPTH];
  logic [FW-1:0] fill_r;
  logic [IW-1:0] wp_r;
  logic          ring_we;
  logic [10:0]   ring_wd;

  // median and report
  logic [IW-1:0] med_i_r;
  logic [10:0]   s_mid_r, s_mid1_r;
  status_t       status_r;
  logic [15:0]   bpm_r;

  // output register
  logic        out_valid_r;
  logic [31:0] o_time_r;
  status_t     o_status_r;
  logic [3:0]  o_beats_r;
  logic [15:0] o_bpm_r;

  // divider
  logic        div_start, div_done;
  logic [31:0] div_a;
  logic [15:0] div_d, div_q, div_rem;

  // combinational helpers
  logic [15:0]           period;
  logic signed [LW-1:0]  x_s, x_in;
  logic signed [LW-1:0]  base_d, base_new, sm_d, sm_new, detr, mag;
  logic signed [PLW-1:0] base_p, sm_p, env_p;
  logic signed [64:0]    var_d;
  logic signed [81:0]    var_p;
  logic signed [63:0]    var_new;
  logic signed [63:0]    sq_ext;
  logic [63:0]           sq_abs;
  logic                  sq_sat;
  logic [22:0]           sq_hi, mul_a, mul_b;
  logic [15:0]           sq_lo;
  logic [45:0]           mul_p;
  logic [63:0]           sq_tot, sq_res;
  logic signed [63:0]    thr64, amp64, env64, sp64;
  logic                  peak;
  logic signed [32:0]    pk_gap, warm_d, lp_d;
  logic [10:0]           med_v;
  logic [FW-1:0]         lt_cnt, le_cnt, mid, mid1;
  logic                  med_last;
  logic [11:0]           m2;
  logic [3:0]            beats;

  assign period = (cfg.report_period_ms == 16'd0) ? 16'd1 : cfg.report_period_ms;
  assign x_s    = $signed({2'b00, ir_r, 16'h0000});
  assign x_in   = $signed({2'b00, q_ir, 16'h0000});

  // coefficient products, each floor(a * c / 65536)
  always_comb begin
    base_d   = x_s - base_r;
    base_p   = PLW'(base_d) * PLW'($signed(K_BASE));
    base_new = base_r + LW'(base_p >>> 16);
    detr     = x_s - base_r;
    sm_d     = detr - sm_r;
    sm_p     = PLW'(sm_d) * PLW'($signed(K_SMOOTH));
    sm_new   = sm_r + LW'(sm_p >>> 16);
    env_p    = PLW'(env_r) * PLW'($signed(K_DECAY));
    var_d    = $signed({1'b0, sq_sm_r}) - 65'(var_r);
    var_p    = 82'(var_d) * 82'($signed(K_BASE));
    var_new  = var_r + 64'(var_p >>> 16);
    mag      = sm_r[LW-1] ? -sm_r : sm_r;
  end

  // squaring unit: |v| split at bit 16, three partial products in turn
  always_comb begin
    sq_ext = 64'(sq_sel_r ? sp_r : sm_r);
    sq_abs = sq_ext[63] ? 64'(-sq_ext) : 64'(sq_ext);
    sq_sat = |sq_abs[63:39];
    sq_hi  = sq_abs[38:16];
    sq_lo  = sq_abs[15:0];
    mul_a  = (state_r == S_SQ_LL) ? {7'b0, sq_lo} : sq_hi;
    mul_b  = (state_r == S_SQ_HH) ? sq_hi : {7'b0, sq_lo};
    mul_p  = mul_a * mul_b;
    sq_tot = acc_r + 64'(mul_p >> 16);
    sq_res = (sq_sat || (sq_tot > SQ_CAP)) ? SQ_CAP : sq_tot;
  end

  // peak test on the previous smoothed value
  always_comb begin
    thr64 = $signed({30'b0, cfg.min_peak_threshold, 16'h0000});
    amp64 = $signed({30'b0, cfg.min_signal_amplitude, 16'h0000});
    env64 = 64'(env_r);
    sp64  = 64'(sp_r);
    peak  = (sp64 > thr64) && (sp_r > 0) &&
            ($signed(sq_sp_r) > (var_r >>> 4)) &&
            (sp_r >= sp2_r) && (sp_r > sm_r);
    pk_gap = $signed({1'b0, pst_r}) - $signed({1'b0, lpt_r});
    warm_d = $signed({1'b0, t_r}) - $signed({1'b0, cst_r});
    lp_d   = $signed({1'b0, t_r}) - $signed({1'b0, lpt_r});
  end

  // rank of the current candidate among the stored intervals
  always_comb begin
    med_v  = ring_r[med_i_r];
    lt_cnt = '0;
    le_cnt = '0;
    for (int j = 0; j < INTERVAL_DEPTH; j++) begin
      if (FW'(j) < fill_r) begin
        lt_cnt = lt_cnt + FW'(ring_r[j] < med_v);
        le_cnt = le_cnt + FW'(ring_r[j] <= med_v);
      end
    end
    mid      = fill_r >> 1;
    mid1     = mid - FW'(1);
    med_last = (FW'(med_i_r) == fill_r - FW'(1));
    m2       = fill_r[0] ? {s_mid_r, 1'b0} : 12'(s_mid1_r) + 12'(s_mid_r);
    beats    = (fill_r != '0) ? 4'(fill_r + FW'(1)) : 4'd0;
  end

  // divider operands
  always_comb begin
    div_start = 1'b0;
    div_a     = 32'(m2 >> 1) + BPM_NUM;
    div_d     = 16'(m2);
    if (state_r == S_RCHK) begin
      div_start = ({1'b0, t_r} >= next_r);
      div_a     = t_r - next_r[31:0];
      div_d     = period;
    end else if (state_r == S_M2) begin
      div_start = (m2 >= MIN_M2) && (m2 <= MAX_M2);
    end
  end

  hre_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_d),
    .done     (div_done),
    .quot     (div_q),
    .rem      (div_rem)
  );

  assign q_pop   = (state_r == S_IDLE) && q_valid;
  assign ring_we = (state_r == S_PEAK) && peak && (lpt_r != 32'd0) &&
                   !(pk_gap < $signed({22'b0, cfg.min_interval_ms})) &&
                   !(pk_gap > $signed({22'b0, cfg.max_interval_ms}));
  assign ring_wd = pk_gap[10:0];

  // interval ring storage
  always_ff @(posedge clk) begin
    if (ring_we) ring_r[wp_r] <= ring_wd;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_IDLE;
      clock_started_r  <= 1'b0;
      next_r           <= '0;
      filter_started_r <= 1'b0;
      contact_r        <= 1'b0;
      fill_r           <= '0;
      wp_r             <= '0;
      lpt_r            <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            t_r  <= q_time;
            ir_r <= q_ir;
            if (!clock_started_r) begin
              clock_started_r <= 1'b1;
              next_r          <= {1'b0, q_time} + 33'(period);
            end
            state_r <= S_RCHK;
            if (!q_finger || !contact_r) begin
              // clear signal state
              filter_started_r <= 1'b0;
              contact_r        <= 1'b0;
              cst_r            <= '0;
              pst_r            <= '0;
              lpt_r            <= '0;
              base_r           <= '0;
              sm_r             <= '0;
              sp_r             <= '0;
              sp2_r            <= '0;
              var_r            <= '0;
              env_r            <= '0;
              fill_r           <= '0;
              wp_r             <= '0;
            end
            if (q_finger) begin
              if (!contact_r) begin
                contact_r <= 1'b1;
                cst_r     <= q_time;
              end
              if (!contact_r || !filter_started_r) begin
                // first sample of a contact only loads the baseline and the sample time
                filter_started_r <= 1'b1;
                base_r           <= x_in;
                pst_r            <= q_time;
              end else begin
                state_r <= S_BASE;
              end
            end
          end
        end
        S_BASE: begin
          base_r  <= base_new;
          state_r <= S_SMOOTH;
        end
        S_SMOOTH: begin
          sm_r     <= sm_new;
          envd_r   <= LW'(env_p >>> 16);
          sq_sel_r <= 1'b0;
          state_r  <= S_SQ_HH;
        end
        S_SQ_HH: begin
          acc_r   <= 64'(mul_p) << 16;
          state_r <= S_SQ_HL;
        end
        S_SQ_HL: begin
          acc_r   <= acc_r + (64'(mul_p) << 1);
          state_r <= S_SQ_LL;
        end
        S_SQ_LL: begin
          if (sq_sel_r) begin
            sq_sp_r <= sq_res;
            state_r <= S_VAR;
          end else begin
            sq_sm_r  <= sq_res;
            sq_sel_r <= 1'b1;
            state_r  <= S_SQ_HH;
          end
        end
        S_VAR: begin
          var_r   <= var_new;
          state_r <= S_PEAK;
        end
        S_PEAK: begin
          env_r <= (mag > envd_r) ? mag : envd_r;
          if (peak) begin
            if (lpt_r == 32'd0) begin
              lpt_r <= pst_r;
            end else if (!(pk_gap < $signed({22'b0, cfg.min_interval_ms}))) begin
              lpt_r <= pst_r;
              if (pk_gap > $signed({22'b0, cfg.max_interval_ms})) begin
                fill_r <= '0;
                wp_r   <= '0;
              end else begin
                wp_r <= (wp_r == IW'(INTERVAL_DEPTH - 1)) ? '0 : wp_r + IW'(1);
                if (fill_r != FW'(INTERVAL_DEPTH)) fill_r <= fill_r + FW'(1);
              end
            end
          end
          sp2_r   <= sp_r;
          sp_r    <= sm_r;
          pst_r   <= t_r;
          state_r <= S_RCHK;
        end
        S_RCHK: begin
          state_r <= div_start ? S_RDIV : S_IDLE;
        end
        S_RDIV: begin
          if (div_done) begin
            next_r  <= {1'b0, t_r} + 33'(period) - 33'(div_rem);
            state_r <= S_STATUS;
          end
        end
        S_STATUS: begin
          bpm_r    <= '0;
          status_r <= STS_INSUFFICIENT;
          state_r  <= S_EMIT;
          priority if (!contact_r) begin
            status_r <= STS_NO_FINGER;
          end else if (warm_d < $signed({17'b0, cfg.warmup_ms})) begin
            status_r <= STS_WARMING_UP;
          end else if (env64 < amp64) begin
            status_r <= STS_POOR_SIGNAL;
          end else if ((8'(fill_r) < 8'(cfg.min_intervals_for_report)) ||
                       (lpt_r == 32'd0) ||
                       (lp_d > $signed({22'b0, cfg.max_interval_ms})) ||
                       (fill_r == '0)) begin
            status_r <= STS_INSUFFICIENT;
          end else begin
            med_i_r <= '0;
            state_r <= S_MED;
          end
        end
        S_MED: begin
          if ((lt_cnt <= mid) && (mid < le_cnt))   s_mid_r  <= med_v;
          if ((lt_cnt <= mid1) && (mid1 < le_cnt)) s_mid1_r <= med_v;
          med_i_r <= med_i_r + IW'(1);
          if (med_last) state_r <= S_M2;
        end
        S_M2: begin
          state_r <= div_start ? S_BDIV : S_EMIT;
        end
        S_BDIV: begin
          if (div_done) begin
            bpm_r    <= div_q;
            status_r <= STS_STABLE;
            state_r  <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            o_time_r    <= t_r;
            o_status_r  <= status_r;
            o_beats_r   <= beats;
            o_bpm_r     <= bpm_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_report_time_ms = o_time_r;
  assign out_status         = o_status_r;
  assign out_beats          = o_beats_r;
  assign out_bpm_q8         = o_bpm_r;

endmodule

// ===== hw/rtl/ppg_heart_rate_estimator_top.sv =====
// Top level of the PPG heart-rate estimator: configuration registers,
// sample queue and processing back end. Depends on hre_pkg, hre_front, hre_back.
//
//   channel  direction  handshake              beat
//   in_      sink       in_valid / in_ready    time, IR level, finger flag
//   out_     source     out_valid / out_ready  report time, status, beats, BPM
//   cfg_     sink       cfg_valid / cfg_ready  register index, write data
//
// A sample without finger or the first of a contact goes from idle straight to
// the report check; a filtered sample passes baseline, smoothing, two squares on
// the shared 23x23 squaring multiplier, variance and peak states. A report adds
// the period divider, then median selection over the stored intervals in turn
// and the rate divider. Reset is synchronous; cfg_ready is always high. A
// two-entry queue and the output register let input and output stall apart.
module ppg_heart_rate_estimator_top
  import hre_pkg::*;
#(
  parameter int INTERVAL_DEPTH = 8,
  parameter int SAMPLE_BITS    = 18
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [31:0]            in_sample_time_ms,
  input  logic [SAMPLE_BITS-1:0] in_ir_level,
  input  logic                   in_finger_on,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [31:0]            out_report_time_ms,
  output logic [2:0]             out_status,
  output logic [3:0]             out_beats,
  output logic [15:0]            out_bpm_q8,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [2:0]             cfg_index,
  input  logic [17:0]            cfg_data
);

  cfg_t                   cfg_r;
  logic                   q_valid, q_pop, q_finger;
  logic [31:0]            q_time;
  logic [SAMPLE_BITS-1:0] q_ir;

  assign cfg_ready = 1'b1;

  // configuration register bank
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_REPORT_PERIOD: cfg_r.report_period_ms         <= cfg_data[15:0];
        REG_WARMUP:        cfg_r.warmup_ms                <= cfg_data[15:0];
        REG_MIN_INTERVAL:  cfg_r.min_interval_ms          <= cfg_data[10:0];
        REG_MAX_INTERVAL:  cfg_r.max_interval_ms          <= cfg_data[10:0];
        REG_MIN_PEAK_THR:  cfg_r.min_peak_threshold       <= cfg_data;
        REG_MIN_AMPLITUDE: cfg_r.min_signal_amplitude     <= cfg_data;
        REG_MIN_INTERVALS: cfg_r.min_intervals_for_report <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  hre_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_sample_time_ms (in_sample_time_ms),
    .in_ir_level       (in_ir_level),
    .in_finger_on      (in_finger_on),
    .q_valid           (q_valid),
    .q_pop             (q_pop),
    .q_time            (q_time),
    .q_ir              (q_ir),
    .q_finger          (q_finger)
  );

  hre_back #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .INTERVAL_DEPTH (INTERVAL_DEPTH)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .q_valid            (q_valid),
    .q_pop              (q_pop),
    .q_time             (q_time),
    .q_ir               (q_ir),
    .q_finger           (q_finger),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_report_time_ms (out_report_time_ms),
    .out_status         (out_status),
    .out_beats          (out_beats),
    .out_bpm_q8         (out_bpm_q8)
  );

endmodule
